>>> sv/motor_telemetry_frame_tracker_top_macros.svh
// Assertion shorthands for the frame tracker; clock and reset are taken from
// the scope of the instantiating module.
`ifndef MOTOR_TELEMETRY_FRAME_TRACKER_TOP_MACROS_SVH
`define MOTOR_TELEMETRY_FRAME_TRACKER_TOP_MACROS_SVH

// Check a condition at every edge outside reset.
`define MTFT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("frame tracker check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define MTFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame tracker sequencing check failed");

`endif

>>> sv/mtft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtft_pkg;

  localparam int FRAME_LEN = 16;
  localparam int BODY_LEN  = FRAME_LEN - 2;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0]  START_MARK      = 8'hFE;
  localparam logic [15:0] UNINIT_POSITION = 16'h7FFF;
  localparam logic [31:0] LIFT_LONG       = 32'd1000;
  localparam logic [31:0] LIFT_SHORT      = 32'd500;
  localparam logic [1:0]  RECOVERY_MAX    = 2'd2;

  // request codes
  localparam logic [2:0] REQ_RX        = 3'd0;
  localparam logic [2:0] REQ_ACK       = 3'd1;
  localparam logic [2:0] REQ_RECOVER   = 3'd2;
  localparam logic [2:0] REQ_POS_RESET = 3'd3;
  localparam logic [2:0] REQ_POLL      = 3'd4;

  // frame events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_GOOD    = 2'd1;
  localparam logic [1:0] EV_BAD     = 2'd2;
  localparam logic [1:0] EV_DISCARD = 2'd3;

  // hook states
  localparam logic [2:0] HS_UNINIT      = 3'd0;
  localparam logic [2:0] HS_CLOSED      = 3'd1;
  localparam logic [2:0] HS_PART_CLOSED = 3'd2;
  localparam logic [2:0] HS_MID         = 3'd3;
  localparam logic [2:0] HS_PART_OPEN   = 3'd4;
  localparam logic [2:0] HS_OPEN        = 3'd5;
  localparam logic [2:0] HS_ERROR       = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_CLOSED_LIMIT     = 3'd0;
  localparam logic [2:0] CFG_MID_POINT        = 3'd1;
  localparam logic [2:0] CFG_OPEN_POINT       = 3'd2;
  localparam logic [2:0] CFG_SLOW_THRESHOLD   = 3'd3;
  localparam logic [2:0] CFG_STOP_COUNT_LIMIT = 3'd4;
  localparam logic [2:0] CFG_PROTECTION_LIMIT = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
  } mtft_in_t;

  typedef struct packed {
    logic [1:0]         frame_event;
    logic [2:0]         hook_state;
    logic               is_stopped;
    logic               at_end_stroke;
    logic               protection_triggered;
    logic [1:0]         recovery_stage;
    logic [7:0]         latched_error;
    logic [2:0]         reply_seq_no;
    logic [15:0]        voltage_mv;
    logic signed [15:0] current_ma;
    logic [15:0]        position;
    logic               ready_for_lifting;
  } mtft_out_t;

  typedef struct packed {
    logic [14:0] closed_limit;
    logic [14:0] mid_point;
    logic [14:0] open_point;
    logic [15:0] slow_threshold;
    logic [3:0]  stop_count_limit;
    logic [14:0] protection_limit;
  } mtft_cfg_t;

  // frame assembler to tracker: event of this word and the decoded fields
  typedef struct packed {
    logic [1:0]  frame_event;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] position;
    logic [7:0]  error_code;
    logic [7:0]  command;
    logic [31:0] data_word;
  } mtft_frame_t;

endpackage
`default_nettype wire

>>> sv/mtft_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module mtft_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output mtft_pkg::mtft_cfg_t    cfg
);
  import mtft_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closed_limit     <= 15'd1;
      cfg.mid_point        <= 15'd13393;
      cfg.open_point       <= 15'd17967;
      cfg.slow_threshold   <= 16'd25;
      cfg.stop_count_limit <= 4'd10;
      cfg.protection_limit <= 15'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOSED_LIMIT:     cfg.closed_limit     <= cfg_data[14:0];
        CFG_MID_POINT:        cfg.mid_point        <= cfg_data[14:0];
        CFG_OPEN_POINT:       cfg.open_point       <= cfg_data[14:0];
        CFG_SLOW_THRESHOLD:   cfg.slow_threshold   <= cfg_data;
        CFG_STOP_COUNT_LIMIT: cfg.stop_count_limit <= cfg_data[3:0];
        CFG_PROTECTION_LIMIT: cfg.protection_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/mtft_frame_rx.sv
`timescale 1ns / 1ps
`default_nettype none
module mtft_frame_rx (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire mtft_pkg::mtft_in_t  item,
  output mtft_pkg::mtft_frame_t    frame
);
  import mtft_pkg::*;

  localparam logic [IDX_W-1:0] TRAILER_INDEX = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(FRAME_LEN - 1);

  logic [7:0]       body [BODY_LEN];
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       fletcher_low;
  logic [7:0]       fletcher_high;
  logic [7:0]       trailer_low;

  logic       take_byte;
  logic       discard;
  logic [8:0] sum_low;
  logic [8:0] sum_high;
  logic [7:0] low_next;
  logic [7:0] high_next;

  assign take_byte = en && (item.req_type == REQ_RX);
  assign discard   = (byte_index == '0) && (item.rx_byte != START_MARK);

  // running sums mod 255: both operands stay below twice the modulus
  always_comb begin
    sum_low  = {1'b0, fletcher_low} + {1'b0, item.rx_byte};
    low_next = (sum_low >= 9'd255) ? 8'(sum_low - 9'd255) : sum_low[7:0];
    sum_high  = {1'b0, fletcher_high} + {1'b0, low_next};
    high_next = (sum_high >= 9'd255) ? 8'(sum_high - 9'd255) : sum_high[7:0];
  end

  always_comb begin
    frame.frame_event = EV_NONE;
    if (take_byte) begin
      if (discard) begin
        frame.frame_event = EV_DISCARD;
      end else if (byte_index == LAST_INDEX) begin
        frame.frame_event = (trailer_low == fletcher_low && item.rx_byte == fletcher_high)
                            ? EV_GOOD : EV_BAD;
      end
    end
    frame.voltage    = {body[3], body[2]};
    frame.current    = {body[5], body[4]};
    frame.position   = {body[7], body[6]};
    frame.error_code = body[8];
    frame.command    = body[9];
    frame.data_word  = {body[13], body[12], body[11], body[10]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      fletcher_low  <= '0;
      fletcher_high <= '0;
      trailer_low   <= '0;
    end else if (take_byte && !discard) begin
      if (byte_index < TRAILER_INDEX) begin
        fletcher_low  <= low_next;
        fletcher_high <= high_next;
        byte_index    <= byte_index + 1'b1;
      end else if (byte_index == TRAILER_INDEX) begin
        trailer_low <= item.rx_byte;
        byte_index  <= byte_index + 1'b1;
      end else begin
        byte_index    <= '0;
        fletcher_low  <= '0;
        fletcher_high <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte && !discard && byte_index < TRAILER_INDEX) begin
      body[byte_index] <= item.rx_byte;
    end
  end

endmodule
`default_nettype wire

>>> sv/mtft_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
module mtft_tracker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire mtft_pkg::mtft_in_t   item,
  input  wire mtft_pkg::mtft_frame_t frame,
  input  wire mtft_pkg::mtft_cfg_t  cfg,
  output mtft_pkg::mtft_out_t       result
);
  import mtft_pkg::*;

  logic [15:0] hook_position, hook_position_next;
  logic [15:0] previous_position, previous_position_next;
  logic [3:0]  slow_count, slow_count_next;
  logic        stopped_flag, stopped_flag_next;
  logic [15:0] voltage_reg, voltage_reg_next;
  logic [15:0] current_reg, current_reg_next;
  logic [7:0]  error_latch, error_latch_next;
  logic [2:0]  seq_reg, seq_reg_next;
  logic [1:0]  recovery_reg, recovery_reg_next;
  logic [31:0] lifting_timer, lifting_timer_next;

  logic        ready;
  logic [15:0] delta;
  logic [4:0]  slow_inc;
  logic        end_stroke;

  function automatic logic [2:0] hook_class(input logic [15:0] p, input mtft_cfg_t c);
    logic [15:0] closed_w, mid_w, open_w;
    closed_w = {1'b0, c.closed_limit};
    mid_w    = {1'b0, c.mid_point};
    open_w   = {1'b0, c.open_point};
    if (p <= closed_w || p[15])      return HS_CLOSED;
    else if (p < mid_w)              return HS_PART_CLOSED;
    else if (p == mid_w)             return HS_MID;
    else if (p < open_w)             return HS_PART_OPEN;
    else if (p == open_w)            return HS_OPEN;
    else if (p == UNINIT_POSITION)   return HS_UNINIT;
    else                             return HS_ERROR;
  endfunction

  always_comb begin
    hook_position_next     = hook_position;
    previous_position_next = previous_position;
    slow_count_next        = slow_count;
    stopped_flag_next      = stopped_flag;
    voltage_reg_next       = voltage_reg;
    current_reg_next       = current_reg;
    error_latch_next       = error_latch;
    seq_reg_next           = seq_reg;
    recovery_reg_next      = recovery_reg;
    lifting_timer_next     = lifting_timer;
    ready                  = 1'b0;

    delta = (previous_position > frame.position) ? previous_position - frame.position
                                                 : frame.position - previous_position;
    slow_inc = {1'b0, slow_count} + 5'd1;

    if (en) begin
      case (item.req_type)
        REQ_RX: begin
          if (frame.frame_event == EV_GOOD) begin
            hook_position_next     = frame.position;
            previous_position_next = frame.position;
            if (delta < cfg.slow_threshold) begin
              if (slow_inc > {1'b0, cfg.stop_count_limit}) begin
                slow_count_next   = cfg.stop_count_limit;
                stopped_flag_next = 1'b1;
              end else begin
                slow_count_next   = slow_inc[3:0];
                stopped_flag_next = 1'b0;
              end
            end else begin
              slow_count_next   = '0;
              stopped_flag_next = 1'b0;
            end
            voltage_reg_next = frame.voltage;
            current_reg_next = frame.current;
            if (error_latch == '0) begin
              error_latch_next = frame.error_code;
            end
            seq_reg_next = frame.command[2:0];
            if (frame.command[3]) begin
              lifting_timer_next = frame.data_word;
            end
          end
        end
        REQ_ACK: error_latch_next = '0;
        REQ_RECOVER: begin
          if (recovery_reg < RECOVERY_MAX) begin
            recovery_reg_next = recovery_reg + 1'b1;
          end
        end
        REQ_POS_RESET: begin
          recovery_reg_next  = '0;
          hook_position_next = '0;
        end
        REQ_POLL: begin
          if (lifting_timer != '0) begin
            ready = 1'b1;
            if (lifting_timer >= LIFT_LONG) begin
              lifting_timer_next = LIFT_SHORT;
            end else if (lifting_timer >= LIFT_SHORT) begin
              lifting_timer_next = '0;
            end
          end
        end
        default: ;
      endcase
    end

    end_stroke = hook_position_next[15] && (recovery_reg_next == '0) && stopped_flag_next;

    result.frame_event          = frame.frame_event;
    result.hook_state           = hook_class(hook_position_next, cfg);
    result.is_stopped           = stopped_flag_next;
    result.at_end_stroke        = end_stroke;
    result.protection_triggered = end_stroke
                                  && (hook_position_next[14:0] > cfg.protection_limit);
    result.recovery_stage       = recovery_reg_next;
    result.latched_error        = error_latch_next;
    result.reply_seq_no         = seq_reg_next;
    result.voltage_mv           = voltage_reg_next;
    result.current_ma           = current_reg_next;
    result.position             = hook_position_next;
    result.ready_for_lifting    = ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hook_position     <= UNINIT_POSITION;
      previous_position <= UNINIT_POSITION;
      slow_count        <= '0;
      stopped_flag      <= 1'b0;
      voltage_reg       <= '0;
      current_reg       <= '0;
      error_latch       <= '0;
      seq_reg           <= '0;
      recovery_reg      <= '0;
      lifting_timer     <= '0;
    end else if (en) begin
      hook_position     <= hook_position_next;
      previous_position <= previous_position_next;
      slow_count        <= slow_count_next;
      stopped_flag      <= stopped_flag_next;
      voltage_reg       <= voltage_reg_next;
      current_reg       <= current_reg_next;
      error_latch       <= error_latch_next;
      seq_reg           <= seq_reg_next;
      recovery_reg      <= recovery_reg_next;
      lifting_timer     <= lifting_timer_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/motor_telemetry_frame_tracker_top.sv
// Channel  Direction  Handshake          Word
// in       receive    in_valid/in_stall  mtft_in_t  (req_type, rx_byte)
// out      send       out_valid/out_stall mtft_out_t (event, hook status, telemetry)
// cfg      receive    cfg_we             cfg_index selects register, cfg_data
//
// One word in, one word out; a new word is taken every cycle while the output is free.
// The path has two registers: the input register, then tracker logic into the result register.
// Reset is synchronous on rst and restores all control state and register defaults.
// A stall on out holds both stages and raises in_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "motor_telemetry_frame_tracker_top_macros.svh"
module motor_telemetry_frame_tracker_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mtft_pkg::mtft_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mtft_pkg::mtft_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import mtft_pkg::*;

  logic        advance;
  logic        s1_valid;
  mtft_in_t    s1_item;
  logic        step_en;
  mtft_cfg_t   cfg;
  mtft_frame_t frame;
  mtft_out_t   result;

  // advance both stages whenever the result register is free or being emptied
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign step_en  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  // payload registers: no reset, hold while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= in_data;
    end
    if (step_en) begin
      out_data <= result;
    end
  end

  mtft_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtft_frame_rx u_frame (
    .clk   (clk),
    .rst   (rst),
    .en    (step_en),
    .item  (s1_item),
    .frame (frame)
  );

  mtft_tracker u_track (
    .clk    (clk),
    .rst    (rst),
    .en     (step_en),
    .item   (s1_item),
    .frame  (frame),
    .cfg    (cfg),
    .result (result)
  );

  `MTFT_ASSERT_NEXT(a_accept_loads_stage, in_valid && !in_stall, s1_valid)
  `MTFT_ASSERT_NEXT(a_step_loads_result, step_en, out_valid)
  `MTFT_ASSERT_NEXT(a_stall_holds_stage, !advance, $stable(s1_item) && $stable(s1_valid))
  `MTFT_ASSERT_ALWAYS(a_end_stroke_cause,
    !(out_valid && out_data.at_end_stroke) || out_data.is_stopped)

endmodule
`default_nettype wire
